### rtl/raid_parity_mismatch_scanner_assert.svh
// Assertion macros shared by the scanner's checker.
`ifndef RAID_PARITY_MISMATCH_SCANNER_ASSERT_SVH
`define RAID_PARITY_MISMATCH_SCANNER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define RPMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define RPMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define RPMS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rpms_pkg.sv
// Types and constants of the RAID parity mismatch scanner.
package rpms_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DISK_FIELDS = 8;
  localparam int unsigned SECTOR_W    = 48;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned DC_W        = 4;
  localparam int unsigned SW_W        = 11;

  localparam int unsigned IN_TDATA_W  = DISK_FIELDS * WORD_W + SECTOR_W;
  localparam int unsigned OUT_TDATA_W = 2 * SECTOR_W + LEN_W;

  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_WORDS = 8'd1;

  localparam logic [DC_W-1:0] DC_RESET = 4'd3;
  localparam logic [DC_W-1:0] DC_MIN   = 4'd2;
  localparam logic [SW_W-1:0] SW_RESET = 11'd128;
  localparam logic [SW_W-1:0] SW_MAX   = 11'd1024;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                kind;
    logic [SECTOR_W-1:0] first;
    logic [SECTOR_W-1:0] last;
    logic [LEN_W-1:0]    len;
    logic                last_ev;
  } event_t;

  // Events produced by one transfer; push_b implies push_a.
  typedef struct packed {
    logic   push_a;
    logic   push_b;
    event_t ev_a;
    event_t ev_b;
  } push_t;

endpackage

### rtl/rpms_xor_lane.sv
// One disk lane: gates the disk word by the active-disk enable.
module rpms_xor_lane import rpms_pkg::*; (
  input  logic              en,
  input  logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] word_gated
);

  assign word_gated = en ? word : '0;

endmodule

### rtl/rpms_parity_merge.sv
// Merge stage: XOR of all lane words and the nonzero parity flag.
module rpms_parity_merge import rpms_pkg::*; #(
  parameter int unsigned NUM_LANES = 8
) (
  input  logic [WORD_W-1:0] lane_word [NUM_LANES],
  output logic              mismatch
);

  logic [WORD_W-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      acc = acc ^ lane_word[i];
    end
  end

  assign mismatch = |acc;

endmodule

### rtl/rpms_run_tracker.sv
// Sector and bad-run tracking; emits up to two events per transfer.
module rpms_run_tracker import rpms_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                mismatch,
  input  logic [SECTOR_W-1:0] sector,
  input  logic [SW_W-1:0]     sw_eff,
  output push_t               push
);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                sbad_r, sbad_nxt;
  logic                open_r, open_nxt;
  logic [SECTOR_W-1:0] first_r, first_nxt;
  logic [SECTOR_W-1:0] last_r, last_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [SECTOR_W-1:0] cur_r, cur_nxt;

  logic                brk, open1, sbad1, sec_end;
  logic                ev_b_vld;
  logic [LEN_W-1:0]    cnt1;
  logic [SECTOR_W-1:0] cur1;
  event_t              brk_ev, end_ev;

  always_comb begin
    // run broken by a sector number that does not follow on
    brk   = (pos_r == '0) && open_r && (sector != (cur_r + SECTOR_W'(1)));
    open1 = open_r && !brk;
    cnt1  = brk ? '0 : cnt_r;
    cur1  = (pos_r == '0) ? sector : cur_r;
    sbad1 = sbad_r || mismatch;
    sec_end = ({1'b0, pos_r} + SW_W'(1)) >= sw_eff;

    brk_ev = '{kind: KIND_END, first: first_r, last: last_r, len: cnt_r, last_ev: 1'b1};
    end_ev = '{kind: KIND_END, first: first_r, last: last_r, len: cnt1, last_ev: 1'b1};

    pos_nxt   = pos_r + POS_W'(1);
    sbad_nxt  = sbad1;
    open_nxt  = open1;
    first_nxt = first_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt1;
    cur_nxt   = cur1;
    ev_b_vld  = 1'b0;

    if (sec_end) begin
      pos_nxt  = '0;
      sbad_nxt = 1'b0;
      if (sbad1) begin
        if (!open1) begin
          open_nxt  = 1'b1;
          first_nxt = cur1;
          last_nxt  = cur1;
          cnt_nxt   = LEN_W'(1);
          ev_b_vld  = 1'b1;
          end_ev    = '{kind: KIND_START, first: cur1, last: cur1, len: LEN_W'(1),
                        last_ev: 1'b1};
        end else begin
          cnt_nxt  = (cnt1 != '1) ? cnt1 + LEN_W'(1) : cnt1;
          last_nxt = cur1;
        end
      end else if (open1) begin
        open_nxt = 1'b0;
        cnt_nxt  = '0;
        ev_b_vld = 1'b1;
      end
    end

    // pack: the first event always goes into slot a
    push = '0;
    if (accept) begin
      if (brk) begin
        push.push_a = 1'b1;
        push.ev_a   = brk_ev;
        push.push_b = ev_b_vld;
        push.ev_b   = end_ev;
        push.ev_a.last_ev = !ev_b_vld;
      end else begin
        push.push_a = ev_b_vld;
        push.ev_a   = end_ev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sbad_r  <= 1'b0;
      open_r  <= 1'b0;
      first_r <= '0;
      last_r  <= '0;
      cnt_r   <= '0;
      cur_r   <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      sbad_r  <= sbad_nxt;
      open_r  <= open_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
    end
  end

endmodule

### rtl/rpms_event_fifo.sv
// Small event queue; takes up to two events per cycle, gives one.
module rpms_event_fifo import rpms_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output logic   room2,
  output logic   head_vld,
  output event_t head
);

  event_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_pop;

  assign head_vld = cnt_r != '0;
  assign head     = mem_r[rd_r];
  assign room2    = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_nxt  = wr_r + FIFO_PTR_W'(push.push_a) + FIFO_PTR_W'(push.push_b);
    rd_nxt  = rd_r + FIFO_PTR_W'(do_pop);
    cnt_nxt = cnt_r + FIFO_CNT_W'(push.push_a) + FIFO_CNT_W'(push.push_b)
              - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.push_a) mem_r[wr_r] <= push.ev_a;
    if (push.push_b) mem_r[wr_r + FIFO_PTR_W'(1)] <= push.ev_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/raid_parity_mismatch_scanner.sv
// Top level of the RAID parity mismatch scanner.
// An event raised by an input transfer enters the event queue and is offered on out_ once at its head.
// Throughput: one word position per cycle; in_tready drops only while the
// four-entry event queue has fewer than two free slots (set by out_ draining).
// Reset (rst_n low, synchronous): queue emptied, sector and run state cleared,
// disk_count back to 3 and sector_words back to 128.
module raid_parity_mismatch_scanner import rpms_pkg::*; #(
  parameter int unsigned MAX_DISKS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // word_disk0..word_disk7 (32b each), sector_number (48b), low bits first
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // first_sector (48b), last_sector (48b), run_length (32b), low bits first
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // event_kind (1b)
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready
);

  // config registers, taken raw and clamped on use
  logic [DC_W-1:0] disk_count_r;
  logic [SW_W-1:0] sector_words_r;
  logic [DC_W-1:0] dc_eff;
  logic [SW_W-1:0] sw_eff;

  logic              in_xfer;
  logic [WORD_W-1:0] lane_word [MAX_DISKS];
  logic              mismatch;
  push_t             push;
  logic              room2;
  event_t            head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_count_r   <= DC_RESET;
      sector_words_r <= SW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DISK_COUNT:   disk_count_r   <= cfg_data[DC_W-1:0];
        CFG_SECTOR_WORDS: sector_words_r <= cfg_data[SW_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // too few disks acts as two, too many as all lanes; empty sector acts as one word
  always_comb begin
    if (disk_count_r < DC_MIN)                 dc_eff = DC_MIN;
    else if (disk_count_r > DC_W'(MAX_DISKS))  dc_eff = DC_W'(MAX_DISKS);
    else                                       dc_eff = disk_count_r;
    if (sector_words_r == '0)                  sw_eff = SW_W'(1);
    else if (sector_words_r > SW_MAX)          sw_eff = SW_MAX;
    else                                       sw_eff = sector_words_r;
  end

  assign in_tready = room2;
  assign in_xfer   = in_tvalid && in_tready;

  // one lane per member disk
  for (genvar g = 0; g < MAX_DISKS; g++) begin : g_lane
    rpms_xor_lane u_lane (
      .en         (DC_W'(g) < dc_eff),
      .word       (in_tdata[g*WORD_W +: WORD_W]),
      .word_gated (lane_word[g])
    );
  end

  rpms_parity_merge #(.NUM_LANES(MAX_DISKS)) u_merge (
    .lane_word (lane_word),
    .mismatch  (mismatch)
  );

  rpms_run_tracker u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_xfer),
    .mismatch (mismatch),
    .sector   (in_tdata[DISK_FIELDS*WORD_W +: SECTOR_W]),
    .sw_eff   (sw_eff),
    .push     (push)
  );

  // output queue decouples event transfers from input transfers
  rpms_event_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_tready),
    .room2    (room2),
    .head_vld (out_tvalid),
    .head     (head)
  );

  assign out_tdata = {head.len, head.last, head.first};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_ev;

endmodule

### rtl/rpms_checker.sv
// Port-level checker for the scanner, bound to the top level.
`include "raid_parity_mismatch_scanner_assert.svh"

module rpms_checker import rpms_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  `RPMS_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "event offered right after reset")

  `RPMS_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata), "stalled event changed")

  `RPMS_ASSERT_IMP(a_start_shape, out_tvalid && (out_tuser == KIND_START),
                   (out_tdata[OUT_TDATA_W-1 -: LEN_W] == LEN_W'(1)) &&
                   (out_tdata[SECTOR_W-1:0] == out_tdata[2*SECTOR_W-1:SECTOR_W]) &&
                   out_tlast, "malformed run start event")

  `RPMS_ASSERT_IMP(a_end_len, out_tvalid && (out_tuser == KIND_END),
                   out_tdata[OUT_TDATA_W-1 -: LEN_W] != '0, "run end with zero length")

endmodule

bind raid_parity_mismatch_scanner rpms_checker u_rpms_checker (.*);
